@@ src/md2_message_digest_unit_macros.svh @@
// ----------------------------------------------------------------------------
// md2_message_digest_unit_macros.svh
// Assertion macros shared by the MD2 digest unit.
// ----------------------------------------------------------------------------
`ifndef MD2_MESSAGE_DIGEST_UNIT_MACROS_SVH
`define MD2_MESSAGE_DIGEST_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define MD2_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define MD2_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/md2_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md2_pkg
// Constants, S-box, control word types and microcode ROM of the MD2 unit.
// ----------------------------------------------------------------------------
package md2_pkg;

  localparam int BLK_LEN  = 16;
  localparam int RING_LEN = 48;
  localparam int ROUNDS   = 18;
  localparam int CNT_W    = $clog2(RING_LEN);
  localparam int RND_W    = $clog2(ROUNDS);
  localparam int FILL_W   = $clog2(BLK_LEN);
  localparam int PAD_W    = FILL_W + 1;
  localparam int PC_W     = 3;

  localparam logic [7:0] SBOX [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

  // Microcode step kinds.
  typedef enum logic [2:0] {
    K_WAIT,
    K_SETUP,
    K_MIX,
    K_BRANCH,
    K_PAD,
    K_EMIT
  } kind_t;

  // Microcode addresses.
  localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] PC_SETUP  = 3'd1;
  localparam logic [PC_W-1:0] PC_MIX    = 3'd2;
  localparam logic [PC_W-1:0] PC_BRANCH = 3'd3;
  localparam logic [PC_W-1:0] PC_PAD    = 3'd4;
  localparam logic [PC_W-1:0] PC_EMIT   = 3'd5;

  typedef struct packed {
    kind_t           kind;
    logic [PC_W-1:0] next;
  } uword_t;

  // Control bundle from sequencer to datapath.
  typedef struct packed {
    logic             take_byte;
    logic             latch_pad;
    logic             pad_shift;
    logic             setup;
    logic             ring_rot;
    logic             first;
    logic             cks_upd;
    logic             src_cks;
    logic             mix;
    logic             round_end;
    logic             emit;
    logic             last;
    logic             clear;
    logic [RND_W-1:0] rnd;
  } ctl_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:   w = '{kind: K_WAIT,   next: PC_SETUP};
      PC_SETUP:  w = '{kind: K_SETUP,  next: PC_MIX};
      PC_MIX:    w = '{kind: K_MIX,    next: PC_BRANCH};
      PC_BRANCH: w = '{kind: K_BRANCH, next: PC_IDLE};
      PC_PAD:    w = '{kind: K_PAD,    next: PC_SETUP};
      PC_EMIT:   w = '{kind: K_EMIT,   next: PC_IDLE};
      default:   w = '{kind: K_WAIT,   next: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ src/md2_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md2_in_if
// Message byte channel: valid/ready with byte, byte flag and end marker.
// ----------------------------------------------------------------------------
interface md2_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, msg_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, msg_byte, has_byte, end_of_message, output ready);
endinterface

@@ src/md2_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md2_out_if
// Digest byte channel: valid/ready with digest byte and last marker.
// ----------------------------------------------------------------------------
interface md2_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  logic       digest_last;

  modport source (output valid, digest_byte, digest_last, input ready);
  modport sink   (input valid, digest_byte, digest_last, output ready);
endinterface

@@ src/md2_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md2_seq
// Microcode sequencer: step counter, loop counters and conditional jumps.
// ----------------------------------------------------------------------------
module md2_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_has,
  input  logic           in_eom,
  input  logic           out_free,
  input  logic           fill_last,
  output logic           in_ready,
  output md2_pkg::ctl_t  ctl
);

  typedef enum logic [1:0] {
    BLK_MSG,
    BLK_FINAL,
    BLK_CKS
  } blk_t;

  localparam logic [md2_pkg::CNT_W-1:0] RING_END = md2_pkg::CNT_W'(md2_pkg::RING_LEN - 1);
  localparam logic [md2_pkg::CNT_W-1:0] BLK_END  = md2_pkg::CNT_W'(md2_pkg::BLK_LEN - 1);
  localparam logic [md2_pkg::CNT_W-1:0] BLK_CNT  = md2_pkg::CNT_W'(md2_pkg::BLK_LEN);
  localparam logic [md2_pkg::RND_W-1:0] RND_END  = md2_pkg::RND_W'(md2_pkg::ROUNDS - 1);

  logic [md2_pkg::PC_W-1:0]  pc, pc_next;
  logic [md2_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [md2_pkg::RND_W-1:0] rnd, rnd_next;
  blk_t                      blk, blk_next;
  logic                      eom_pend, eom_pend_next;
  md2_pkg::uword_t           uw;

  always_comb begin
    uw            = md2_pkg::ucode(pc);
    ctl           = '0;
    ctl.rnd       = rnd;
    in_ready      = 1'b0;
    pc_next       = pc;
    cnt_next      = cnt;
    rnd_next      = rnd;
    blk_next      = blk;
    eom_pend_next = eom_pend;
    unique case (uw.kind)
      md2_pkg::K_WAIT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.take_byte = in_has;
          if (in_has && fill_last) begin
            pc_next       = uw.next;
            blk_next      = BLK_MSG;
            eom_pend_next = in_eom;
          end else if (in_eom) begin
            pc_next       = md2_pkg::PC_PAD;
            ctl.latch_pad = 1'b1;
          end
        end
      end
      md2_pkg::K_SETUP: begin
        ctl.setup    = 1'b1;
        ctl.ring_rot = (cnt < BLK_CNT);
        ctl.first    = (cnt == '0);
        ctl.cks_upd  = (blk != BLK_CKS);
        ctl.src_cks  = (blk == BLK_CKS);
        if (cnt == RING_END) begin
          cnt_next = '0;
          pc_next  = uw.next;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      md2_pkg::K_MIX: begin
        ctl.mix       = 1'b1;
        ctl.round_end = (cnt == RING_END);
        if (cnt == RING_END) begin
          cnt_next = '0;
          if (rnd == RND_END) begin
            rnd_next = '0;
            pc_next  = uw.next;
          end else begin
            rnd_next = rnd + 1'b1;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      md2_pkg::K_BRANCH: begin
        case (blk)
          BLK_FINAL: begin
            blk_next = BLK_CKS;
            pc_next  = md2_pkg::PC_SETUP;
          end
          BLK_CKS: pc_next = md2_pkg::PC_EMIT;
          default: begin
            if (eom_pend) begin
              pc_next       = md2_pkg::PC_PAD;
              ctl.latch_pad = 1'b1;
            end else begin
              pc_next = uw.next;
            end
          end
        endcase
      end
      md2_pkg::K_PAD: begin
        ctl.pad_shift = 1'b1;
        if (fill_last) begin
          blk_next = BLK_FINAL;
          pc_next  = uw.next;
        end
      end
      md2_pkg::K_EMIT: begin
        if (out_free) begin
          ctl.emit = 1'b1;
          ctl.last = (cnt == BLK_END);
          if (cnt == BLK_END) begin
            ctl.clear     = 1'b1;
            cnt_next      = '0;
            pc_next       = uw.next;
            blk_next      = BLK_MSG;
            eom_pend_next = 1'b0;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: pc_next = md2_pkg::PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= md2_pkg::PC_IDLE;
      cnt      <= '0;
      rnd      <= '0;
      blk      <= BLK_MSG;
      eom_pend <= 1'b0;
    end else begin
      pc       <= pc_next;
      cnt      <= cnt_next;
      rnd      <= rnd_next;
      blk      <= blk_next;
      eom_pend <= eom_pend_next;
    end
  end

endmodule

@@ src/md2_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md2_datapath
// Mixing ring, block and checksum rings, S-box lookups and digest register.
// ----------------------------------------------------------------------------
module md2_datapath (
  input  logic          clk,
  input  logic          rst,
  input  md2_pkg::ctl_t ctl,
  input  logic [7:0]    msg_byte,
  output logic          fill_last,
  output logic [7:0]    out_byte,
  output logic          out_last
);

  localparam int RL = md2_pkg::RING_LEN;
  localparam int BL = md2_pkg::BLK_LEN;

  logic [7:0]                mix_ring [RL];
  logic [7:0]                blk_ring [BL];
  logic [7:0]                cks_ring [BL];
  logic [7:0]                t_reg;
  logic [7:0]                l_reg;
  logic [md2_pkg::FILL_W-1:0] fill, fill_next;
  logic [md2_pkg::PAD_W-1:0]  pad;

  logic [7:0] blk_head;
  logic [7:0] mix_new;
  logic [7:0] l_eff;
  logic [7:0] cks_new;

  assign blk_head  = ctl.src_cks ? cks_ring[0] : blk_ring[0];
  assign mix_new   = mix_ring[0] ^ md2_pkg::SBOX[t_reg];
  assign l_eff     = ctl.first ? cks_ring[BL-1] : l_reg;
  assign cks_new   = cks_ring[0] ^ md2_pkg::SBOX[blk_ring[0] ^ l_eff];
  assign fill_last = (fill == md2_pkg::FILL_W'(BL - 1));
  assign fill_next = (ctl.take_byte || ctl.pad_shift) ? fill + 1'b1 : fill;

  // Mixing state: a 48-byte ring that rotates one byte per step.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int k = 0; k < RL; k++) mix_ring[k] <= '0;
    end else if (ctl.setup || ctl.mix || ctl.emit) begin
      for (int k = 0; k < RL - 1; k++) mix_ring[k] <= mix_ring[k+1];
      mix_ring[RL-1] <= ctl.mix ? mix_new : mix_ring[0];
      if (ctl.setup && ctl.ring_rot) begin
        mix_ring[BL-1]   <= blk_head;
        mix_ring[2*BL-1] <= blk_head ^ mix_ring[0];
      end
    end
  end

  // Running checksum ring.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int k = 0; k < BL; k++) cks_ring[k] <= '0;
    end else if (ctl.setup && ctl.ring_rot) begin
      for (int k = 0; k < BL - 1; k++) cks_ring[k] <= cks_ring[k+1];
      cks_ring[BL-1] <= ctl.cks_upd ? cks_new : cks_ring[0];
    end
  end

  // Block buffer: bytes enter at the tail, rotate during setup.
  always_ff @(posedge clk) begin
    if (ctl.take_byte || ctl.pad_shift) begin
      for (int k = 0; k < BL - 1; k++) blk_ring[k] <= blk_ring[k+1];
      blk_ring[BL-1] <= ctl.take_byte ? msg_byte : 8'(pad);
    end else if (ctl.setup && ctl.ring_rot) begin
      for (int k = 0; k < BL - 1; k++) blk_ring[k] <= blk_ring[k+1];
      blk_ring[BL-1] <= blk_ring[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_pad) begin
      pad <= md2_pkg::PAD_W'(BL) - {1'b0, fill_next};
    end
    if (ctl.setup) begin
      t_reg <= '0;
    end else if (ctl.mix) begin
      t_reg <= ctl.round_end ? mix_new + {3'b0, ctl.rnd} : mix_new;
    end
    if (ctl.setup && ctl.ring_rot) begin
      l_reg <= cks_new;
    end
    if (ctl.emit) begin
      out_byte <= mix_ring[0];
      out_last <= ctl.last;
    end
  end

endmodule

@@ src/md2_message_digest_unit.sv @@
`timescale 1ns / 1ps
// The 16th byte of a block starts a block pass (setup steps over the ring,
//   18 rounds of mixing steps, then a branch step); input is held off meanwhile.
// End of message: pad bytes of value (16 - fill) complete the block, then two
//   block passes (padded block and checksum block), then 16 digest transfers,
//   one per cycle when drained. The mixing ring steps one byte per cycle through
//   its single S-box lookup. Synchronous active-high reset.
// ----------------------------------------------------------------------------
// md2_message_digest_unit
// MD2 hash unit: byte stream in, 16 digest bytes out per message.
// ----------------------------------------------------------------------------
`include "md2_message_digest_unit_macros.svh"

module md2_message_digest_unit (
  input  logic      clk,
  input  logic      rst,
  md2_in_if.sink    msg,
  md2_out_if.source digest
);

  md2_pkg::ctl_t ctl;
  logic          fill_last;
  logic          out_valid;
  logic          out_free;
  logic [7:0]    out_byte;
  logic          out_last;

  // The digest register frees up when empty or when its byte transfers this
  // cycle, so emission runs at one byte per cycle under a ready sink.
  assign out_free = !out_valid || digest.ready;

  // Sequencer: walks the microcode ROM, owns the input handshake and all
  // loop counters (ring step, round, digest byte); the block fill count is in the datapath.
  md2_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (msg.valid),
    .in_has    (msg.has_byte),
    .in_eom    (msg.end_of_message),
    .out_free  (out_free),
    .fill_last (fill_last),
    .in_ready  (msg.ready),
    .ctl       (ctl)
  );

  // Datapath: rotating rings for mixing state, block buffer and checksum.
  md2_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .msg_byte  (msg.msg_byte),
    .fill_last (fill_last),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // Output valid: set on a load, drop once the byte transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (digest.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign digest.valid       = out_valid;
  assign digest.digest_byte = out_byte;
  assign digest.digest_last = out_last;

  // A digest byte never lands on top of one still waiting.
  `MD2_ASSERT_NOW(a_emit_free, ctl.emit, out_free, "digest register overwritten")
  // After the last digest byte the unit takes the next message at once.
  `MD2_ASSERT_NEXT(a_clear_idle, ctl.clear, msg.ready, "not idle after digest")
  // A mixing pass always follows a setup pass.
  `MD2_ASSERT_NOW(a_mix_after_setup, $rose(ctl.mix), $past(ctl.setup),
    "mixing started without setup")

endmodule

@@ bench/md2_message_digest_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md2_message_digest_unit_tb
// Self-checking bench for the MD2 digest unit. Message bytes go in over the
// byte channel and a model of the MD2 algorithm is advanced on every accepted
// transfer. Every digest byte that leaves the unit is checked in order against
// the bytes the model predicted. Directed cases come first, then random
// messages with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module md2_message_digest_unit_tb;

  localparam int DRAIN_CYCLES = 64;     // quiet time after the last digest byte
  localparam int QUIET_LIMIT  = 12000;  // well above three block passes plus pad
  localparam int RANDOM_ITEMS = 206;

  typedef logic [15:0][7:0] blk16_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } digest_item_t;

  logic clk;
  logic rst;

  md2_in_if  msg_if ();
  md2_out_if digest_if ();

  md2_message_digest_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if),
    .digest (digest_if)
  );

  // --------------------------------------------------------------------------
  // Digest model: mixing ring, running checksum, partial block and its fill.
  // --------------------------------------------------------------------------
  logic [47:0][7:0] mix_ring;
  blk16_t           run_cks;
  blk16_t           part_blk;
  logic [3:0]       part_fill;

  digest_item_t digest_expected[$];

  bit gaps_on;          // both sides draw idle cycles when set
  bit msg_valid_drv;    // mirror of the valid we last scheduled
  int fail_count;
  int bytes_sent;
  int msgs_sent;
  int digests_checked;

  function automatic void md2_clear_state();
    mix_ring  = '0;
    run_cks   = '0;
    part_blk  = '0;
    part_fill = '0;
  endfunction

  // Run the 18-round S-box mix of one block into the ring.
  function automatic void md2_absorb_block(input blk16_t blk);
    logic [7:0] t;
    for (int i = 0; i < 16; i++) begin
      mix_ring[16 + i] = blk[i];
      mix_ring[32 + i] = blk[i] ^ mix_ring[i];
    end
    t = '0;
    for (int r = 0; r < 18; r++) begin
      for (int i = 0; i < 48; i++) begin
        mix_ring[i] = mix_ring[i] ^ md2_pkg::SBOX[t];
        t = mix_ring[i];
      end
      t = t + 8'(r);
    end
  endfunction

  // XOR form of the checksum update, chained through the previous byte.
  function automatic void md2_fold_checksum(input blk16_t blk);
    logic [7:0] l;
    l = run_cks[15];
    for (int i = 0; i < 16; i++) begin
      run_cks[i] = run_cks[i] ^ md2_pkg::SBOX[blk[i] ^ l];
      l = run_cks[i];
    end
  endfunction

  // Advance the model by one accepted transfer; queue the digest on an end.
  function automatic void md2_predict_transfer(input logic [7:0] data, input logic carries,
                                               input logic ends);
    logic [4:0]   pad;
    digest_item_t d;
    if (carries) begin
      part_blk[part_fill] = data;
      if (part_fill == 4'd15) begin
        md2_absorb_block(part_blk);
        md2_fold_checksum(part_blk);
        part_fill = '0;
      end else begin
        part_fill = part_fill + 4'd1;
      end
    end
    if (ends) begin
      // Pad with N bytes of N; a full pad block when nothing is pending.
      pad = 5'd16 - {1'b0, part_fill};
      for (int i = 0; i < 16; i++) begin
        if (i >= part_fill) part_blk[i] = {3'b000, pad};
      end
      md2_absorb_block(part_blk);
      md2_fold_checksum(part_blk);
      md2_absorb_block(run_cks);
      for (int i = 0; i < 16; i++) begin
        d.digest_byte = mix_ring[i];
        d.digest_last = (i == 15);
        digest_expected.push_back(d);
      end
      md2_clear_state();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock generation.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Byte channel driver.
  // --------------------------------------------------------------------------

  // Drop valid unless it is already low.
  task automatic park_input();
    if (msg_valid_drv) begin
      msg_if.valid  <= 1'b0;
      msg_valid_drv  = 1'b0;
    end
  endtask

  // Present one item, hold it until the unit takes it, then update the model.
  task automatic send_item(input logic [7:0] data, input logic carries, input logic ends);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      park_input();
      repeat (gap) @(posedge clk);
    end
    msg_if.valid          <= 1'b1;
    msg_if.msg_byte       <= data;
    msg_if.has_byte       <= carries;
    msg_if.end_of_message <= ends;
    msg_valid_drv          = 1'b1;
    do @(posedge clk); while (!msg_if.ready);
    md2_predict_transfer(data, carries, ends);
    if (carries) bytes_sent++;
    if (ends) msgs_sent++;
  endtask

  // Hold off the sender until every predicted digest byte has come out.
  task automatic wait_for_digests();
    park_input();
    do @(posedge clk); while (digest_expected.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Digest channel: random backpressure and in-order checking.
  // --------------------------------------------------------------------------
  initial begin
    int           stall;
    digest_item_t want;
    digest_if.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = gaps_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        digest_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      digest_if.ready <= 1'b1;
      do @(posedge clk); while (!(digest_if.valid === 1'b1 && digest_if.ready === 1'b1));
      if (digest_expected.size() == 0) begin
        $error("unexpected digest transfer: digest_byte %02h digest_last %0b",
               digest_if.digest_byte, digest_if.digest_last);
        fail_count++;
      end else begin
        want = digest_expected.pop_front();
        digests_checked++;
        if (digest_if.digest_byte !== want.digest_byte) begin
          $error("digest_byte: expected %02h, got %02h", want.digest_byte,
                 digest_if.digest_byte);
          fail_count++;
        end
        if (digest_if.digest_last !== want.digest_last) begin
          $error("digest_last: expected %0b, got %0b", want.digest_last,
                 digest_if.digest_last);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when neither channel moves for too long.
  // --------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((msg_if.valid === 1'b1 && msg_if.ready === 1'b1) ||
          (digest_if.valid === 1'b1 && digest_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
    $display("[md2_message_digest_unit] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // End marker alone: one block of sixteen 16s, then the checksum block.
  task automatic test_empty_message();
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0 | 1'b1);
  endtask

  // Byte and end in one transfer: the byte is taken before the message ends.
  task automatic test_byte_with_end();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
  endtask

  // Transfers with neither byte nor end must leave the message untouched.
  task automatic test_idle_transfers();
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Exactly one block, back to back with no idling, then a full pad block.
  // Afterwards the sender holds off until the digest has drained.
  task automatic test_full_block();
    gaps_on = 1'b0;
    for (int i = 0; i < 16; i++) begin
      send_item((i % 2 == 0) ? 8'h00 : 8'hFF, 1'b1, 1'b0);
    end
    send_item(8'hA5, 1'b0, 1'b1);
    wait_for_digests();
    gaps_on = 1'b1;
  endtask

  // Random messages: mostly short, some whole blocks, some spanning blocks,
  // with stray idle transfers mixed in and the odd drain pause.
  task automatic test_random_messages(input int target);
    int   sent;
    int   len;
    logic joint_end;
    sent = 0;
    while (sent < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       len = 16 * $urandom_range(1, 2);
        1:       len = $urandom_range(17, 40);
        default: len = $urandom_range(0, 15);
      endcase
      joint_end = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          sent++;
        end
        send_item(8'($urandom_range(0, 255)), 1'b1, joint_end && (k == len - 1));
        sent++;
      end
      if (!joint_end) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) wait_for_digests();
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    fail_count      = 0;
    bytes_sent      = 0;
    msgs_sent       = 0;
    digests_checked = 0;
    gaps_on         = 1'b1;
    msg_valid_drv   = 1'b0;
    md2_clear_state();

    rst                   <= 1'b1;
    msg_if.valid          <= 1'b0;
    msg_if.msg_byte       <= 8'h00;
    msg_if.has_byte       <= 1'b0;
    msg_if.end_of_message <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_message();
    test_byte_with_end();
    test_idle_transfers();
    test_full_block();
    test_random_messages(RANDOM_ITEMS);

    // Drain, then leave room for any stray output.
    wait_for_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d message bytes in %0d messages; checked %0d digest bytes.",
             bytes_sent, msgs_sent, digests_checked);
    if (fail_count == 0) begin
      $display("[md2_message_digest_unit] OK");
    end else begin
      $display("[md2_message_digest_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/md2_pkg.sv
src/md2_in_if.sv
src/md2_out_if.sv
src/md2_seq.sv
src/md2_datapath.sv
src/md2_message_digest_unit.sv
bench/md2_message_digest_unit_tb.sv
